@@ src/clm_pkg.sv @@
// ----------------------------------------------------------------------------
// clm_pkg
// Shared types, codes and sizes for the client liveness monitor.
// ----------------------------------------------------------------------------
package clm_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [1:0] CMD_REGISTER = 2'd0;
    localparam logic [1:0] CMD_REMOVE   = 2'd1;
    localparam logic [1:0] CMD_REPLY    = 2'd2;
    localparam logic [1:0] CMD_TICK     = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;

    localparam logic [1:0] CFG_REPLY_TIMEOUT    = 2'd0;
    localparam logic [1:0] CFG_REQUEST_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_MISS_LIMIT       = 2'd2;
    localparam logic [1:0] CFG_FIRST_MISS_LIMIT = 2'd3;

    localparam logic [15:0] RST_REPLY_TIMEOUT    = 16'd50;
    localparam logic [15:0] RST_REQUEST_INTERVAL = 16'd300;
    localparam logic [7:0]  RST_MISS_LIMIT       = 8'd3;
    localparam logic [7:0]  RST_FIRST_MISS_LIMIT = 8'd10;

    localparam logic [7:0] GENERIC_MODE    = 8'hFF;
    localparam logic [6:0] FLAG_KEEP_LIMIT = 7'd3;
    localparam logic [6:0] EPISODE_CAP     = 7'd100;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [3:0]        slot;
        logic signed [7:0] mode_id;
        logic [7:0]        reply_request_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] slot_out;
        logic [7:0] active_mask;
        logic [7:0] unresponsive_mask;
        logic       request_started;
        logic [7:0] current_round;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_busy;
    } t_ctl_sts;

endpackage

@@ src/client_liveness_monitor_top.sv @@
// ----------------------------------------------------------------------------
// client_liveness_monitor_top
// Client slot table polled in numbered request rounds, one result per item.
// ----------------------------------------------------------------------------
// Each accepted item is handled in a load step, which reads the stored mode id
// of the addressed slot from the mode table RAM, and a commit step, which updates
// the slot table (the timeout pass covers all slots at once) and loads the result
// register. No new item is taken until the current one has committed;
// a held result delays only the commit of the next item. Configuration writes
// land at once and belong in idle periods.
// ----------------------------------------------------------------------------
module client_liveness_monitor_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  clm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output clm_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import clm_pkg::*;

    t_ctl_cmd ctl_cmd;
    t_ctl_sts ctl_sts;

    clm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (ctl_sts),
        .o_cmd      (ctl_cmd)
    );

    clm_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctl_cmd),
        .o_sts       (ctl_sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ src/clm_ram.sv @@
// ----------------------------------------------------------------------------
// clm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/clm_ctrl.sv @@
// ----------------------------------------------------------------------------
// clm_ctrl
// Sequencer: take one transfer, wait for the mode table read and a free result register, commit.
// ----------------------------------------------------------------------------
module clm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  clm_pkg::t_ctl_sts i_sts,
    output clm_pkg::t_ctl_cmd o_cmd
);
    import clm_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/clm_datapath.sv @@
// ----------------------------------------------------------------------------
// clm_datapath
// Slot table, round timer, configuration registers and result register.
// ----------------------------------------------------------------------------
module clm_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clm_pkg::t_ctl_cmd  i_cmd,
    output clm_pkg::t_ctl_sts  o_sts,
    input  clm_pkg::t_in_item  i_in_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output clm_pkg::t_out_item o_out_data
);
    import clm_pkg::*;

    logic [15:0] r_timeout;
    logic [15:0] r_interval;
    logic [7:0]  r_miss_limit;
    logic [7:0]  r_first_miss;

    t_in_item r_item;

    logic [NUM_SLOTS-1:0] r_active;
    logic [NUM_SLOTS-1:0] r_answered;
    logic [NUM_SLOTS-1:0] r_awf;
    logic [NUM_SLOTS-1:0] r_flag;
    logic [NUM_SLOTS-1:0] r_generic;
    logic [7:0]           r_miss [NUM_SLOTS];
    logic [6:0]           r_ep   [NUM_SLOTS];
    logic [7:0]           r_round;
    logic [15:0]          r_elapsed;
    logic                 r_started;
    logic                 r_timed_out;

    logic [NUM_SLOTS-1:0] n_active;
    logic [NUM_SLOTS-1:0] n_answered;
    logic [NUM_SLOTS-1:0] n_awf;
    logic [NUM_SLOTS-1:0] n_flag;
    logic [NUM_SLOTS-1:0] n_generic;
    logic [7:0]           n_miss [NUM_SLOTS];
    logic [6:0]           n_ep   [NUM_SLOTS];
    logic [7:0]           n_round;
    logic [15:0]          n_elapsed;
    logic                 n_started;
    logic                 n_timed_out;

    t_out_item r_out_data;
    t_out_item n_out_data;
    logic      r_out_valid;

    logic [SLOT_W-1:0] found;
    logic              full;
    logic [SLOT_W-1:0] sidx;
    logic              slot_ok;
    logic [7:0]        mode_rd;
    logic [SLOT_W-1:0] ram_raddr;
    logic              ram_we;

    assign sidx      = r_item.slot[SLOT_W-1:0];
    assign slot_ok   = ({1'b0, r_item.slot} < 5'(NUM_SLOTS)) && r_active[sidx];
    assign ram_raddr = i_cmd.load ? i_in_data.slot[SLOT_W-1:0] : sidx;
    assign ram_we    = i_cmd.commit && (r_item.cmd == CMD_REGISTER) && !full;

    clm_ram #(
        .WIDTH (8),
        .DEPTH (NUM_SLOTS)
    ) u_mode_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (found),
        .i_wdata ($unsigned(r_item.mode_id)),
        .i_raddr (ram_raddr),
        .o_rdata (mode_rd)
    );

    always_comb begin
        found = '0;
        full  = 1'b1;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                found = SLOT_W'(i);
                full  = 1'b0;
            end
        end
    end

    always_comb begin
        logic [15:0] el_inc;
        logic        do_timeout;
        logic [7:0]  lim;
        logic [7:0]  miss_inc;

        n_active    = r_active;
        n_answered  = r_answered;
        n_awf       = r_awf;
        n_flag      = r_flag;
        n_generic   = r_generic;
        n_miss      = r_miss;
        n_ep        = r_ep;
        n_round     = r_round;
        n_elapsed   = r_elapsed;
        n_started   = r_started;
        n_timed_out = r_timed_out;
        el_inc      = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
        do_timeout  = 1'b0;
        lim         = '0;
        miss_inc    = '0;

        n_out_data                 = '0;
        n_out_data.status          = STATUS_OK;

        case (r_item.cmd)
            CMD_REGISTER: begin
                if (full) begin
                    n_out_data.status = STATUS_FULL;
                end else begin
                    n_active[found]     = 1'b1;
                    n_generic[found]    = ($unsigned(r_item.mode_id) == GENERIC_MODE);
                    n_awf[found]        = 1'b1;
                    n_miss[found]       = '0;
                    n_flag[found]       = 1'b0;
                    n_ep[found]         = '0;
                    n_out_data.slot_out = 3'(found);
                end
            end
            CMD_REMOVE: begin
                if (slot_ok && (mode_rd == $unsigned(r_item.mode_id))) begin
                    n_active[sidx] = 1'b0;
                end else begin
                    n_out_data.status = STATUS_MISMATCH;
                end
            end
            CMD_REPLY: begin
                if (slot_ok && (r_item.reply_request_id == r_round)) begin
                    n_answered[sidx] = 1'b1;
                    n_miss[sidx]     = '0;
                    n_awf[sidx]      = 1'b0;
                    if (r_ep[sidx] <= FLAG_KEEP_LIMIT) begin
                        n_flag[sidx] = 1'b0;
                    end
                end else begin
                    n_out_data.status = STATUS_MISMATCH;
                end
            end
            CMD_TICK: begin
                n_elapsed = el_inc;
                if (r_active != '0) begin
                    do_timeout = r_started && (r_answered != r_active) &&
                                 (el_inc > r_timeout) && !r_timed_out;
                    if (do_timeout) begin
                        n_timed_out = 1'b1;
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            lim      = r_awf[i] ? r_first_miss : r_miss_limit;
                            miss_inc = (r_miss[i] == 8'hFF) ? r_miss[i] : r_miss[i] + 8'd1;
                            if (r_active[i] && !r_answered[i] && !r_flag[i]) begin
                                n_miss[i] = miss_inc;
                                if (miss_inc > lim) begin
                                    if (r_generic[i]) begin
                                        n_active[i] = 1'b0;
                                    end else begin
                                        n_flag[i] = 1'b1;
                                        if (r_ep[i] < EPISODE_CAP) begin
                                            n_ep[i] = r_ep[i] + 7'd1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                    if (!r_started || (el_inc > r_interval)) begin
                        n_answered                 = '0;
                        n_elapsed                  = '0;
                        n_timed_out                = 1'b0;
                        n_round                    = r_round + 8'd1;
                        n_started                  = 1'b1;
                        n_out_data.request_started = 1'b1;
                    end
                end
            end
            default: n_out_data.status = STATUS_OK;
        endcase

        n_out_data.active_mask       = 8'(n_active);
        n_out_data.unresponsive_mask = 8'(n_active & n_flag);
        n_out_data.current_round     = n_round;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= RST_REPLY_TIMEOUT;
            r_interval   <= RST_REQUEST_INTERVAL;
            r_miss_limit <= RST_MISS_LIMIT;
            r_first_miss <= RST_FIRST_MISS_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REPLY_TIMEOUT:    r_timeout    <= i_cfg_data;
                CFG_REQUEST_INTERVAL: r_interval   <= i_cfg_data;
                CFG_MISS_LIMIT:       r_miss_limit <= i_cfg_data[7:0];
                CFG_FIRST_MISS_LIMIT: r_first_miss <= i_cfg_data[7:0];
                default:              r_timeout    <= r_timeout;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.commit) begin
            r_generic  <= n_generic;
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_answered  <= '0;
            r_awf       <= '0;
            r_flag      <= '0;
            r_round     <= '0;
            r_elapsed   <= '0;
            r_started   <= 1'b0;
            r_timed_out <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_miss[i] <= '0;
                r_ep[i]   <= '0;
            end
        end else begin
            if (i_cmd.commit) begin
                r_active    <= n_active;
                r_answered  <= n_answered;
                r_awf       <= n_awf;
                r_flag      <= n_flag;
                r_miss      <= n_miss;
                r_ep        <= n_ep;
                r_round     <= n_round;
                r_elapsed   <= n_elapsed;
                r_started   <= n_started;
                r_timed_out <= n_timed_out;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

endmodule

@@ src/clm_checker.sv @@
// ----------------------------------------------------------------------------
// clm_checker
// Port-level checks on the result channel of the liveness monitor.
// ----------------------------------------------------------------------------
module clm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input clm_pkg::t_out_item o_out_data
);
    import clm_pkg::*;

    a_reset_no_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_flag_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.unresponsive_mask & ~o_out_data.active_mask) == 8'd0)
        else $error("flagged slot not active");

    a_start_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.request_started |-> o_out_data.status == STATUS_OK)
        else $error("round start with error status");

    a_full_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == STATUS_FULL) |->
            (o_out_data.active_mask == 8'({NUM_SLOTS{1'b1}})) &&
            (o_out_data.slot_out == 3'd0))
        else $error("table full reported with free slot");

endmodule

bind client_liveness_monitor_top clm_checker u_clm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
